// ===== src/dhcp_option_parser_assert.svh =====
// assertion macros shared by the dhcp option parser checker
// no dependencies; included by the checker file only
`ifndef DHCP_OPTION_PARSER_ASSERT_SVH
`define DHCP_OPTION_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DOP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dop_pkg.sv =====
// types and constants for the dhcp option parser
// no dependencies; imported by dhcp_option_parser and its checker
`timescale 1ns / 1ps

package dop_pkg;

    localparam int DNS_SLOTS = 3;
    // dns addresses visible on the result port
    localparam int OUT_DNS   = 3;
    localparam int SHOW_DNS  = (DNS_SLOTS < OUT_DNS) ? DNS_SLOTS : OUT_DNS;
    localparam int CNT_W     = ($clog2(DNS_SLOTS + 1) < 2) ? 2 : $clog2(DNS_SLOTS + 1);

    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_MASK      = 8'd1;
    localparam logic [7:0] OPT_ROUTER    = 8'd3;
    localparam logic [7:0] OPT_DNS       = 8'd6;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_END       = 8'd255;

    localparam logic [7:0] COOKIE_BYTES [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

    typedef logic [31:0] t_addr;

    typedef enum logic [2:0] {
        PH_COOKIE,
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       cookie_ok;
        logic [7:0] msg_type;
        t_addr      server_id;
        t_addr      subnet_mask;
        t_addr      router_addr;
        t_addr      dns_first;
        t_addr      dns_second;
        t_addr      dns_third;
        logic [1:0] dns_total;
    } t_out_item;

endpackage

// ===== src/dhcp_option_parser.sv =====
// dhcp options-area parser: cookie check, tlv walk and lease field capture
// depends on dop_pkg
`timescale 1ns / 1ps

// Takes one options byte per clock, magic cookie first, and returns one lease
// result for each byte marked last_byte. Each accepted byte is held in an input
// register and parsed from there by a single pass of phase logic; the result
// for a last byte is written to the output register at the edge that parses it.
// Throughput is one byte per cycle. The input stalls only when a last byte is
// waiting while the previous result is still held by a stalled output.
// After each result the parser returns to its reset state.
module dhcp_option_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dop_pkg::t_in_item i_in,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output dop_pkg::t_out_item o_out,
    input  logic              i_out_stall
);
    import dop_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_item  r_in;

    // parse state
    t_phase     r_phase, n_phase;
    logic [1:0] r_cookie_idx, n_cookie_idx;
    logic       r_cookie_good, n_cookie_good;
    logic [7:0] r_code, n_code;
    logic [7:0] r_len, n_len;
    logic [7:0] r_seen, n_seen;
    t_addr      r_asm, n_asm;
    t_addr      r_staged [DNS_SLOTS];
    t_addr      n_staged [DNS_SLOTS];

    // lease state
    logic [7:0]       r_msg, n_msg;
    t_addr            r_server, n_server;
    t_addr            r_mask, n_mask;
    t_addr            r_router, n_router;
    t_addr            r_lease_dns [DNS_SLOTS];
    t_addr            n_lease_dns [DNS_SLOTS];
    logic [CNT_W-1:0] r_count, n_count;

    // output register
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic      advance;
    logic      finish;
    logic      commit;
    logic      good_nxt;
    logic [7:0] byte_v;
    t_addr     addr_v;
    t_addr     dns_pad [OUT_DNS];

    assign byte_v  = r_in.opt_byte;
    assign advance = r_in_valid && (!r_in.last_byte || !r_out_valid || !i_out_stall);
    assign finish  = advance && r_in.last_byte;

    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    // next state: one byte through the phase logic, option commit folded in
    always_comb begin
        n_phase       = r_phase;
        n_cookie_idx  = r_cookie_idx;
        n_cookie_good = r_cookie_good;
        n_code        = r_code;
        n_len         = r_len;
        n_seen        = r_seen;
        n_asm         = r_asm;
        n_staged      = r_staged;
        n_msg         = r_msg;
        n_server      = r_server;
        n_mask        = r_mask;
        n_router      = r_router;
        n_lease_dns   = r_lease_dns;
        n_count       = r_count;
        commit        = 1'b0;
        good_nxt      = r_cookie_good;
        addr_v        = '0;
        if (advance) begin
            case (r_phase)
                PH_COOKIE: begin
                    good_nxt      = r_cookie_good && (byte_v == COOKIE_BYTES[r_cookie_idx]);
                    n_cookie_good = good_nxt;
                    if (r_cookie_idx == 2'd3) begin
                        n_phase = good_nxt ? PH_CODE : PH_DONE;
                    end else begin
                        n_cookie_idx = r_cookie_idx + 2'd1;
                    end
                end
                PH_CODE: begin
                    if (byte_v == OPT_END) begin
                        n_phase = PH_DONE;
                    end else if (byte_v != OPT_PAD) begin
                        n_code  = byte_v;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len  = byte_v;
                    n_seen = '0;
                    n_asm  = '0;
                    for (int k = 0; k < DNS_SLOTS; k++) begin
                        n_staged[k] = '0;
                    end
                    if (byte_v == 8'd0) begin
                        commit = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (r_code == OPT_MSG_TYPE) begin
                        if (r_seen == 8'd0) begin
                            n_asm = {24'd0, byte_v};
                        end
                    end else if (r_code == OPT_DNS) begin
                        n_asm = {r_asm[23:0], byte_v};
                        // a full group of four lands in its staging slot
                        if (r_seen[1:0] == 2'b11) begin
                            for (int k = 0; k < DNS_SLOTS; k++) begin
                                if (r_seen[7:2] == 6'(k)) begin
                                    n_staged[k] = n_asm;
                                end
                            end
                        end
                    end else if (r_seen < 8'd4) begin
                        n_asm = {r_asm[23:0], byte_v};
                    end
                    n_seen = r_seen + 8'd1;
                    if (n_seen == r_len) begin
                        commit = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (commit) begin
                n_phase = PH_CODE;
                addr_v  = (n_len >= 8'd4) ? n_asm : '0;
                case (r_code)
                    OPT_MSG_TYPE: begin
                        if (n_len != 8'd0) begin
                            n_msg = n_asm[7:0];
                        end
                    end
                    OPT_SERVER_ID: n_server = addr_v;
                    OPT_MASK:      n_mask   = addr_v;
                    OPT_ROUTER:    n_router = addr_v;
                    OPT_DNS: begin
                        n_lease_dns = n_staged;
                        n_count     = (n_len[7:2] > 6'(DNS_SLOTS)) ? CNT_W'(DNS_SLOTS)
                                                                   : CNT_W'(n_len[7:2]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result formed from the state after the last byte
    always_comb begin
        for (int j = 0; j < OUT_DNS; j++) begin
            dns_pad[j] = '0;
        end
        for (int j = 0; j < SHOW_DNS; j++) begin
            if (CNT_W'(j) < n_count) begin
                dns_pad[j] = n_lease_dns[j];
            end
        end
        n_out = '0;
        if ((n_phase != PH_COOKIE) && n_cookie_good) begin
            n_out.cookie_ok   = 1'b1;
            n_out.msg_type    = n_msg;
            n_out.server_id   = n_server;
            n_out.subnet_mask = n_mask;
            n_out.router_addr = n_router;
            n_out.dns_first   = dns_pad[0];
            n_out.dns_second  = dns_pad[1];
            n_out.dns_third   = dns_pad[2];
            n_out.dns_total   = (n_count > CNT_W'(3)) ? 2'd3 : n_count[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_phase       <= PH_COOKIE;
            r_cookie_idx  <= '0;
            r_cookie_good <= 1'b1;
            r_code        <= '0;
            r_len         <= '0;
            r_seen        <= '0;
            r_asm         <= '0;
            r_msg         <= '0;
            r_server      <= '0;
            r_mask        <= '0;
            r_router      <= '0;
            r_count       <= '0;
            for (int k = 0; k < DNS_SLOTS; k++) begin
                r_staged[k]    <= '0;
                r_lease_dns[k] <= '0;
            end
        end else begin
            r_phase       <= n_phase;
            r_cookie_idx  <= n_cookie_idx;
            r_cookie_good <= n_cookie_good;
            r_code        <= n_code;
            r_len         <= n_len;
            r_seen        <= n_seen;
            r_asm         <= n_asm;
            r_msg         <= n_msg;
            r_server      <= n_server;
            r_mask        <= n_mask;
            r_router      <= n_router;
            r_count       <= n_count;
            r_staged      <= n_staged;
            r_lease_dns   <= n_lease_dns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/dop_checker.sv =====
// port-level checks for the dhcp option parser, bound to the top level
// depends on dop_pkg and dhcp_option_parser_assert.svh
`timescale 1ns / 1ps
`include "dhcp_option_parser_assert.svh"

module dop_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input dop_pkg::t_in_item  i_in,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input dop_pkg::t_out_item o_out,
    input logic               i_out_stall
);
    import dop_pkg::*;

    logic      out_held;
    logic      out_kept;
    logic      bad_cookie;
    logic      fields_zero;
    logic      dns_tail_zero;
    t_out_item r_prev_out;

    always_ff @(posedge i_clk) begin
        r_prev_out <= o_out;
    end

    assign out_held    = o_out_valid && i_out_stall;
    assign out_kept    = o_out_valid && (o_out == r_prev_out);
    assign bad_cookie  = o_out_valid && !o_out.cookie_ok;
    assign fields_zero = o_out.msg_type == 8'd0 && o_out.server_id == '0
                         && o_out.subnet_mask == '0 && o_out.router_addr == '0
                         && o_out.dns_first == '0 && o_out.dns_second == '0
                         && o_out.dns_third == '0 && o_out.dns_total == 2'd0;
    assign dns_tail_zero = (o_out.dns_total != 2'd0 || o_out.dns_first == '0)
                           && (o_out.dns_total == 2'd2 || o_out.dns_total == 2'd3
                               || o_out.dns_second == '0)
                           && (o_out.dns_total == 2'd3 || o_out.dns_third == '0);

    // a held result keeps its value until the transfer
    `DOP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, out_kept, "stalled result changed")

    // input back-pressure only comes from a blocked result
    `DOP_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, out_held, "stall without cause")

    // a failed cookie clears every field
    `DOP_ASSERT_IMP(a_bad_cookie_zero, i_clk, i_rst_n, bad_cookie, fields_zero, "nonzero fields")

    // dns addresses past the count read as zero
    `DOP_ASSERT_IMP(a_dns_beyond_count, i_clk, i_rst_n, o_out_valid, dns_tail_zero, "dns past count")

endmodule

bind dhcp_option_parser dop_checker u_dop_checker (.*);
